FILE: sv/oul_pkg.sv
// oul_pkg: shared constants, codes and control types of the ordered unique list store
// no dependencies; imported by every module of the block

package oul_pkg;

  localparam int OUL_CAPACITY = 16;
  localparam int OUL_WORD_W   = 32;
  localparam int OUL_CMD_W    = 3;
  localparam int OUL_POS_W    = 5;
  localparam int OUL_CNT_W    = 5;
  localparam int OUL_ST_W     = 2;

  // command codes
  localparam logic [OUL_CMD_W-1:0] CMD_APPEND    = 3'd0;
  localparam logic [OUL_CMD_W-1:0] CMD_PREPEND   = 3'd1;
  localparam logic [OUL_CMD_W-1:0] CMD_MOVE_LAST = 3'd2;
  localparam logic [OUL_CMD_W-1:0] CMD_READ      = 3'd3;
  localparam logic [OUL_CMD_W-1:0] CMD_REMOVE    = 3'd4;

  // result status codes
  localparam logic [OUL_ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [OUL_ST_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [OUL_ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [OUL_ST_W-1:0] ST_BADPOS  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_MISS,
    S_SWAP_RD,
    S_SWAP_MV,
    S_SWAP_WR,
    S_SHIFT_UP,
    S_PUT_FRONT,
    S_SCAN_RM,
    S_FINISH
  } state_t;

  // where a scan starts
  typedef enum logic [1:0] {
    SCAN_ZERO,
    SCAN_LAST,
    SCAN_POS
  } scan_sel_t;

  // what the store write port does
  typedef enum logic [2:0] {
    WR_NONE,
    WR_APPEND,
    WR_FRONT,
    WR_UP,
    WR_DOWN,
    WR_SLOT,
    WR_LAST
  } wr_sel_t;

  typedef struct packed {
    logic                  load;
    logic                  scan_start;
    scan_sel_t             scan_sel;
    logic                  scan_step;
    logic                  scan_down;
    wr_sel_t               wr_sel;
    logic                  cnt_inc;
    logic                  cnt_dec;
    logic                  slot_cap;
    logic                  cap_data;
    logic                  set_status;
    logic [OUL_ST_W-1:0]   status_code;
    logic                  out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OUL_CMD_W-1:0] cmd;
    logic                 hit;
    logic                 at_last;
    logic                 at_pos;
    logic                 at_zero;
    logic                 empty;
    logic                 full;
    logic                 bad_pos;
    logic                 out_busy;
  } dp_stat_t;

endpackage

FILE: sv/oul_ram.sv
// oul_ram: generic single write port, single read port ram with registered read
// depends on oul_pkg for default sizes

module oul_ram import oul_pkg::*; #(
  parameter int WIDTH = OUL_WORD_W,
  parameter int DEPTH = OUL_CAPACITY
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

FILE: sv/oul_ctrl.sv
// oul_ctrl: command sequencer of the ordered unique list store
// depends on oul_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t

module oul_ctrl import oul_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cmd)
          CMD_APPEND, CMD_PREPEND, CMD_MOVE_LAST: begin
            if (stat.empty) begin
              state_next = S_MISS;
            end else begin
              ctl.scan_start = 1'b1;
              ctl.scan_sel   = SCAN_ZERO;
              state_next     = S_SEARCH;
            end
          end
          CMD_READ, CMD_REMOVE: begin
            if (stat.bad_pos) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_BADPOS;
              state_next      = S_FINISH;
            end else begin
              ctl.scan_start = 1'b1;
              ctl.scan_sel   = SCAN_POS;
              state_next     = S_SCAN_RM;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_SEARCH: begin
        ctl.scan_step = 1'b1;
        if (stat.hit) begin
          if (stat.cmd == CMD_MOVE_LAST) begin
            ctl.slot_cap   = 1'b1;
            ctl.scan_start = 1'b1;
            ctl.scan_sel   = SCAN_LAST;
            state_next     = S_SWAP_RD;
          end else begin
            ctl.set_status  = 1'b1;
            ctl.status_code = ST_PRESENT;
            state_next      = S_FINISH;
          end
        end else if (stat.at_last) begin
          state_next = S_MISS;
        end
      end
      S_MISS: begin
        if (stat.full) begin
          ctl.set_status  = 1'b1;
          ctl.status_code = ST_FULL;
          state_next      = S_FINISH;
        end else if (stat.cmd == CMD_PREPEND) begin
          if (stat.empty) begin
            state_next = S_PUT_FRONT;
          end else begin
            ctl.scan_start = 1'b1;
            ctl.scan_sel   = SCAN_LAST;
            state_next     = S_SHIFT_UP;
          end
        end else begin
          ctl.wr_sel  = WR_APPEND;
          ctl.cnt_inc = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_SWAP_RD: begin
        state_next = S_SWAP_MV;
      end
      S_SWAP_MV: begin
        ctl.wr_sel = WR_SLOT;
        state_next = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        ctl.wr_sel = WR_LAST;
        state_next = S_FINISH;
      end
      S_SHIFT_UP: begin
        ctl.scan_step = 1'b1;
        ctl.scan_down = 1'b1;
        if (stat.at_zero) begin
          ctl.wr_sel = WR_UP;
          state_next = S_PUT_FRONT;
        end else if (stat.at_last || stat.hit || stat.at_pos) begin
          ctl.wr_sel = WR_UP;
        end else begin
          ctl.wr_sel = WR_UP;
        end
      end
      S_PUT_FRONT: begin
        ctl.wr_sel  = WR_FRONT;
        ctl.cnt_inc = 1'b1;
        state_next  = S_FINISH;
      end
      S_SCAN_RM: begin
        ctl.scan_step = 1'b1;
        if (stat.at_pos) begin
          ctl.cap_data = 1'b1;
          if (stat.cmd == CMD_READ) begin
            state_next = S_FINISH;
          end
        end else if (stat.at_last || stat.at_zero || stat.hit) begin
          ctl.wr_sel = WR_DOWN;
        end else begin
          ctl.wr_sel = WR_DOWN;
        end
        if (stat.cmd == CMD_REMOVE && stat.at_last) begin
          ctl.cnt_dec = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/oul_dpath.sv
// oul_dpath: entry store, scan pointer, entry count and result register
// depends on oul_pkg and oul_ram; steered by oul_ctrl through dp_cmd_t

module oul_dpath import oul_pkg::*; #(
  parameter int CAPACITY = OUL_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [OUL_CMD_W-1:0]        command,
  input  logic signed [OUL_WORD_W-1:0] value,
  input  logic [OUL_POS_W-1:0]        position,
  input  dp_cmd_t                     ctl,
  output dp_stat_t                    stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUL_WORD_W-1:0] data,
  output logic [OUL_CNT_W-1:0]        count,
  output logic [OUL_ST_W-1:0]         status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [OUL_CMD_W-1:0]  cmd_r;
  logic [OUL_WORD_W-1:0] val_r;
  logic [OUL_POS_W-1:0]  pos_r;
  logic [CW-1:0]         entry_count;
  logic [AW-1:0]         idx;
  logic                  pv;
  logic [AW-1:0]         pidx;
  logic [AW-1:0]         slot;
  logic [OUL_WORD_W-1:0] res_data;
  logic [OUL_ST_W-1:0]   res_status;

  logic [AW-1:0]         last_addr;
  logic [AW-1:0]         pos_addr;
  logic [AW-1:0]         start_addr;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [OUL_WORD_W-1:0] wd;
  logic [OUL_WORD_W-1:0] rd;

  assign last_addr = AW'(entry_count - CW'(1));
  assign pos_addr  = AW'(pos_r - OUL_POS_W'(1));

  always_comb begin
    case (ctl.scan_sel)
      SCAN_ZERO: start_addr = '0;
      SCAN_LAST: start_addr = last_addr;
      SCAN_POS:  start_addr = pos_addr;
      default:   start_addr = '0;
    endcase
  end

  // store write port; shift copies wait until the first read of the scan has landed
  always_comb begin
    we = 1'b1;
    wa = '0;
    wd = val_r;
    case (ctl.wr_sel)
      WR_NONE:   we = 1'b0;
      WR_APPEND: wa = AW'(entry_count);
      WR_FRONT:  wa = '0;
      WR_UP: begin
        we = pv;
        wa = pidx + AW'(1);
        wd = rd;
      end
      WR_DOWN: begin
        we = pv;
        wa = pidx - AW'(1);
        wd = rd;
      end
      WR_SLOT: begin
        wa = slot;
        wd = rd;
      end
      WR_LAST:   wa = last_addr;
      default:   we = 1'b0;
    endcase
  end

  oul_ram #(
    .WIDTH (OUL_WORD_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .ra  (idx),
    .rd  (rd)
  );

  // scan pointer and the read that is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= ctl.scan_step && !ctl.scan_start;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      idx <= start_addr;
    end else if (ctl.scan_step) begin
      idx <= ctl.scan_down ? idx - AW'(1) : idx + AW'(1);
    end
    pidx <= idx;
    if (ctl.slot_cap) begin
      slot <= pidx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r      <= command;
      val_r      <= value;
      pos_r      <= position;
      res_data   <= '0;
      res_status <= ST_DONE;
    end else begin
      if (ctl.cap_data) begin
        res_data <= rd;
      end
      if (ctl.set_status) begin
        res_status <= ctl.status_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (ctl.cnt_inc) begin
      entry_count <= entry_count + CW'(1);
    end else if (ctl.cnt_dec) begin
      entry_count <= entry_count - CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      data   <= res_data;
      count  <= OUL_CNT_W'(entry_count);
      status <= res_status;
    end
  end

  always_comb begin
    stat.cmd      = cmd_r;
    stat.hit      = pv && (rd == val_r);
    stat.at_last  = pv && (pidx == last_addr);
    stat.at_pos   = pv && (pidx == pos_addr);
    stat.at_zero  = pv && (pidx == '0);
    stat.empty    = (entry_count == '0);
    stat.full     = (entry_count == CW'(CAPACITY));
    stat.bad_pos  = (pos_r == '0) || (32'(pos_r) > 32'(entry_count));
    stat.out_busy = out_valid && out_stall;
  end

endmodule

FILE: sv/ordered_unique_list_store.sv
// ordered_unique_list_store: top level of the ordered list of distinct 32-bit values
// depends on oul_pkg, oul_ctrl and oul_dpath (which holds the oul_ram entry store)
//
// usage
// - input channel (in_valid/in_stall) carries one command beat: command, value, position
//   (append if absent, prepend if absent, move or append last, read, remove)
// - output channel (out_valid/out_stall) returns exactly one result beat per command:
//   data (read or removed value, else zero), count after the command, status
// - one command is worked on at a time; in_stall is high from the accepting edge until
//   its result is loaded into the output register, and the next beat can be taken in the cycle after that
// - the entry store is a single ram with one write and one registered read port, so
//   every scan moves one entry per cycle; that port sets the cycle count
// - reset (rst, synchronous) empties the list and drops any result not yet taken;
//   the store contents need no clearing since only entries below the count are read
// - while the receiver stalls, the finished result waits in the output register and
//   the block may already accept and process the next command up to its own result

module ordered_unique_list_store import oul_pkg::*; #(
  parameter int CAPACITY = OUL_CAPACITY
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [OUL_CMD_W-1:0]         command,
  input  logic signed [OUL_WORD_W-1:0] value,
  input  logic [OUL_POS_W-1:0]         position,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [OUL_WORD_W-1:0] data,
  output logic [OUL_CNT_W-1:0]         count,
  output logic [OUL_ST_W-1:0]          status
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  // sequencer: decides which scan, write and count update happens each cycle
  oul_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // datapath: entry store, scan pointer, count and the output register
  oul_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .command   (command),
    .value     (value),
    .position  (position),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (data),
    .count     (count),
    .status    (status)
  );

endmodule

FILE: sv/oul_checker.sv
// oul_checker: port-level assertions for ordered_unique_list_store, bound to the top level
// depends on oul_pkg for status codes and the default capacity

module oul_checker import oul_pkg::*; #(
  parameter int CAPACITY = OUL_CAPACITY
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [OUL_WORD_W-1:0] data,
  input logic [OUL_CNT_W-1:0]         count,
  input logic [OUL_ST_W-1:0]          status
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data) && $stable(count) && $stable(status))
    else $error("result beat changed while stalled");

  // after reset the block is empty and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // a full rejection reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (count == OUL_CNT_W'(CAPACITY)))
    else $error("full status with count below capacity");

  // no data on a rejected or unchanged command
  a_err_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BADPOS || status == ST_PRESENT || status == ST_FULL)
      |-> (data == '0))
    else $error("data not zero on error status");

  // count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CAPACITY >= 32) || (32'(count) <= CAPACITY))
    else $error("count above capacity");

endmodule

bind ordered_unique_list_store oul_checker #(.CAPACITY(CAPACITY)) u_oul_checker (.*);

FILE: dv/testbench.sv
// testbench for ordered_unique_list_store: directed and random command beats checked against
// a mirror of the list kept in the bench; depends on oul_pkg and the block's rtl

module testbench import oul_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = OUL_CAPACITY;
  localparam int POOL_SIZE   = 24;
  localparam int HOLD_CYCLES = 300;
  // worst command is a prepend into a nearly full list
  localparam int END_SETTLE  = 2 * CAPACITY + 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 40;

  // command codes the block treats as no operation
  localparam logic [OUL_CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [OUL_CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [OUL_CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic signed [OUL_WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [OUL_WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [OUL_WORD_W-1:0] data;
    logic [OUL_CNT_W-1:0]         count;
    logic [OUL_ST_W-1:0]          status;
  } list_result_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [OUL_CMD_W-1:0]         command;
  logic signed [OUL_WORD_W-1:0] value;
  logic [OUL_POS_W-1:0]         position;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [OUL_WORD_W-1:0] data;
  logic [OUL_CNT_W-1:0]         count;
  logic [OUL_ST_W-1:0]          status;

  // mirror of the list as the block should hold it after every accepted beat
  logic signed [OUL_WORD_W-1:0] list_mirror [CAPACITY];
  int                           list_len;
  logic signed [OUL_WORD_W-1:0] value_pool [POOL_SIZE];

  // results owed by the block, oldest first
  list_result_t pending_results [$];

  int mismatch_count;
  int cycle_count;
  bit idle_on;    // random gaps on the input and stalls on the output
  int hold_req;   // bumped to ask the receiver for one long hold-off

  ordered_unique_list_store uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .value     (value),
    .position  (position),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (data),
    .count     (count),
    .status    (status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // applies one command to the mirror and gives the result the block owes for it
  function automatic list_result_t apply_command(input logic [OUL_CMD_W-1:0] cmd,
                                                 input logic signed [OUL_WORD_W-1:0] val,
                                                 input logic [OUL_POS_W-1:0] pos);
    list_result_t res;
    int           slot;
    int           k;
    res.data   = '0;
    res.status = ST_DONE;
    slot       = -1;
    if (cmd == CMD_APPEND || cmd == CMD_PREPEND || cmd == CMD_MOVE_LAST) begin
      for (k = 0; k < list_len; k++) begin
        if (slot < 0 && list_mirror[k] == val) slot = k;
      end
      if (slot >= 0) begin
        if (cmd == CMD_MOVE_LAST) begin
          // swap with the last entry; a no-op when it is already last
          list_mirror[slot]         = list_mirror[list_len - 1];
          list_mirror[list_len - 1] = val;
        end else begin
          res.status = ST_PRESENT;
        end
      end else if (list_len >= CAPACITY) begin
        // presence is checked first, so only absent values are turned away here
        res.status = ST_FULL;
      end else if (cmd == CMD_PREPEND) begin
        for (k = list_len; k > 0; k--) list_mirror[k] = list_mirror[k - 1];
        list_mirror[0] = val;
        list_len++;
      end else begin
        list_mirror[list_len] = val;
        list_len++;
      end
    end else if (cmd == CMD_READ || cmd == CMD_REMOVE) begin
      if (pos == 0 || pos > list_len) begin
        res.status = ST_BADPOS;
      end else begin
        res.data = list_mirror[pos - 1];
        if (cmd == CMD_REMOVE) begin
          for (k = pos - 1; k < list_len - 1; k++) list_mirror[k] = list_mirror[k + 1];
          list_len--;
        end
      end
    end
    // spare command codes fall through: data zero, status done, list untouched
    res.count = list_len[OUL_CNT_W-1:0];
    return res;
  endfunction

  // a random value that is not in the list at the moment
  function automatic logic signed [OUL_WORD_W-1:0] fresh_value();
    logic signed [OUL_WORD_W-1:0] v;
    bit                           taken;
    int                           k;
    do begin
      v     = $urandom;
      taken = 1'b0;
      for (k = 0; k < list_len; k++) begin
        if (list_mirror[k] == v) taken = 1'b1;
      end
    end while (taken);
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [OUL_WORD_W-1:0] got,
                                 input logic [OUL_WORD_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  // offers one command beat and waits for the edge that takes it
  task automatic send_command(input logic [OUL_CMD_W-1:0] cmd,
                              input logic signed [OUL_WORD_W-1:0] val,
                              input logic [OUL_POS_W-1:0] pos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    position <= pos;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(apply_command(cmd, val, pos));
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // one random beat; grow leans towards inserts, otherwise towards removes
  task automatic send_random_command(input bit grow);
    logic [OUL_CMD_W-1:0]         cmd;
    logic signed [OUL_WORD_W-1:0] val;
    logic [OUL_POS_W-1:0]         pos;
    int                           roll;
    roll = $urandom_range(0, 99);
    if (roll >= 95) begin
      cmd = CMD_SPARE_5 + OUL_CMD_W'($urandom_range(0, 2));
    end else if (grow) begin
      if (roll < 25)      cmd = CMD_APPEND;
      else if (roll < 45) cmd = CMD_PREPEND;
      else if (roll < 65) cmd = CMD_MOVE_LAST;
      else if (roll < 80) cmd = CMD_READ;
      else                cmd = CMD_REMOVE;
    end else begin
      if (roll < 10)      cmd = CMD_APPEND;
      else if (roll < 18) cmd = CMD_PREPEND;
      else if (roll < 28) cmd = CMD_MOVE_LAST;
      else if (roll < 50) cmd = CMD_READ;
      else                cmd = CMD_REMOVE;
    end
    // values already stored give hits, the pool gives repeats, the rest is wide open
    roll = $urandom_range(0, 99);
    if (roll < 40 && list_len > 0) val = list_mirror[$urandom_range(0, list_len - 1)];
    else if (roll < 75)            val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
    else                           val = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 80)      pos = OUL_POS_W'($urandom_range(1, (list_len == 0) ? 1 : list_len));
    else if (roll < 90) pos = OUL_POS_W'($urandom_range(0, 1) ? 0 : list_len + 1);
    else                pos = OUL_POS_W'($urandom_range(0, 31));
    send_command(cmd, val, pos);
  endtask

  // every command, field extremes and the corner cases on a short list
  task automatic test_directed_cases();
    send_command(CMD_READ, 32'sd0, 5'd1);            // read from an empty list
    send_command(CMD_REMOVE, 32'sd0, 5'd0);          // position zero
    send_command(CMD_APPEND, WORD_MAX, 5'd0);
    send_command(CMD_APPEND, WORD_MIN, 5'd0);
    send_command(CMD_PREPEND, 32'sd0, 5'd0);
    send_command(CMD_PREPEND, -32'sd1, 5'd31);
    send_command(CMD_APPEND, WORD_MAX, 5'd0);        // already present
    send_command(CMD_PREPEND, WORD_MIN, 5'd0);       // already present
    send_command(CMD_MOVE_LAST, 32'sd0, 5'd0);       // present, swaps with the last
    send_command(CMD_MOVE_LAST, 32'sd0, 5'd0);       // already last, nothing moves
    send_command(CMD_MOVE_LAST, 32'sh5A5A_A5A5, 5'd0); // absent, appended
    send_command(CMD_READ, 32'sd0, 5'd0);
    send_command(CMD_READ, 32'sd0, 5'd31);
    send_command(CMD_READ, 32'sd0, 5'd5);            // last entry
    send_command(CMD_READ, 32'sd0, 5'd6);            // one past the end
    send_command(CMD_REMOVE, 32'sd0, 5'd1);          // front
    send_command(CMD_REMOVE, 32'sd0, 5'd4);          // back
    send_command(CMD_REMOVE, 32'sd0, 5'd2);          // middle
    send_command(CMD_REMOVE, 32'sd0, 5'd3);          // above the count
    send_command(CMD_SPARE_5, -32'sd1, 5'd31);
    send_command(CMD_SPARE_6, WORD_MIN, 5'd16);
    send_command(CMD_SPARE_7, WORD_MAX, 5'd1);
  endtask

  // fill to capacity, knock on the full list, then empty it again
  task automatic test_capacity_limits();
    while (list_len < CAPACITY)
      send_command($urandom_range(0, 1) ? CMD_PREPEND : CMD_APPEND, fresh_value(), 5'd0);
    send_command(CMD_APPEND, fresh_value(), 5'd0);
    send_command(CMD_PREPEND, fresh_value(), 5'd0);
    send_command(CMD_MOVE_LAST, fresh_value(), 5'd0);
    send_command(CMD_APPEND, list_mirror[3], 5'd0);    // present wins over full
    send_command(CMD_MOVE_LAST, list_mirror[0], 5'd0); // swap across the whole list
    send_command(CMD_READ, 32'sd0, OUL_POS_W'(CAPACITY));
    send_command(CMD_READ, 32'sd0, OUL_POS_W'(CAPACITY + 1));
    send_command(CMD_REMOVE, 32'sd0, OUL_POS_W'(CAPACITY));
    send_command(CMD_PREPEND, fresh_value(), 5'd0);    // longest shift
    while (list_len > 0)
      send_command(CMD_REMOVE, $urandom, OUL_POS_W'($urandom_range(1, list_len)));
    send_command(CMD_REMOVE, 32'sd0, 5'd1);
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_output_hold();
    int i;
    hold_req <= hold_req + 1;
    for (i = 0; i < 12; i++) send_random_command(1'b1);
  endtask

  task automatic test_random_mix(input int n_items);
    int i;
    for (i = 0; i < n_items; i++) send_random_command((i / 40) % 2 == 0);
  endtask

  // sender stops after each burst until the block has answered everything
  task automatic test_drain_pause();
    int round;
    int i;
    for (round = 0; round < 8; round++) begin
      for (i = 0; i < 10; i++) send_random_command(round % 4 < 2);
      release_input();
      wait_for_results();
    end
  endtask

  // back-to-back beats, no gaps and no stalls
  task automatic test_steady_stream(input int n_items);
    int i;
    idle_on <= 1'b0;
    for (i = 0; i < n_items; i++) send_random_command((i / 30) % 2 == 0);
  endtask

  // receiver: takes result beats, checks them and drives out_stall
  initial begin
    int           stall_left;
    int           hold_left;
    int           hold_seen;
    list_result_t want;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending, data", data, '0);
        end else begin
          want = pending_results.pop_front();
          if (data !== want.data) report_mismatch("data", data, want.data);
          if (count !== want.count)
            report_mismatch("count", 32'(count), 32'(want.count));
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog against a hung block
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ordered_unique_list_store regression: fail");
    $finish;
  end

  initial begin
    int k;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    command  <= CMD_APPEND;
    value    <= '0;
    position <= '0;
    idle_on  <= 1'b1;
    hold_req <= 0;
    list_len       = 0;
    mismatch_count = 0;
    // pool of likely repeats, extremes first, larger than the list so it can overflow
    value_pool[0] = WORD_MIN;
    value_pool[1] = WORD_MAX;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    value_pool[4] = 32'sd1;
    value_pool[5] = WORD_MIN + 1;
    for (k = 6; k < POOL_SIZE; k++) value_pool[k] = $urandom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_capacity_limits();
    test_output_hold();
    test_random_mix(800);
    test_drain_pause();
    test_steady_stream(150);

    release_input();
    wait_for_results();
    // let any stray late beat show up before the verdict
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("ordered_unique_list_store regression: pass");
    else
      $display("ordered_unique_list_store regression: fail");
    $finish;
  end

endmodule
